// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the SM4 RTL
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define SM4_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("SM4 assertion failed");

// Antecedent implies consequent in the same cycle.
`define SM4_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("SM4 assertion failed");

`else

`define SM4_ASSERT(lbl, clk, rst, prop)
`define SM4_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/sm4_pkg.sv -----
// ---------------------------------------------------------------------------
// SM4 package
// Word types, S-box, FK and CK constants, and the two linear transforms.
// ---------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

   typedef logic [31:0] word_type;
   typedef logic [63:0] dword_type;

   localparam int ROUNDS  = 32;
   localparam int RK_AW   = $clog2(ROUNDS);
   localparam int CSR_AW  = 2;

   typedef logic [RK_AW-1:0]  rk_addr_type;
   typedef logic [CSR_AW-1:0] csr_addr_type;

   localparam csr_addr_type REG_KEY_HI = 2'd0;
   localparam csr_addr_type REG_KEY_LO = 2'd1;

   localparam word_type FK [4] = '{32'hA3B1BAC6, 32'h56AA3350,
                                  32'h677D9197, 32'hB27022DC};

   localparam logic [7:0] SBOX [256] = '{
      8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
      8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
      8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
      8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
      8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
      8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
      8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
      8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
      8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
      8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
      8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
      8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
      8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
      8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
      8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
   };

   function automatic word_type rotl32(input word_type v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Byte-wise S-box substitution
   function automatic word_type sub_word(input word_type x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   function automatic word_type lin_data(input word_type t);
      return t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18) ^ rotl32(t, 24);
   endfunction

   function automatic word_type lin_key(input word_type t);
      return t ^ rotl32(t, 13) ^ rotl32(t, 23);
   endfunction

   // CK byte j of word i is (4*i+j)*7 mod 256
   function automatic word_type ck_word(input rk_addr_type i);
      word_type w;
      logic [7:0] b;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         b = 8'({i, 2'(j)}) * 8'd7;
         w = {w[23:0], b};
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sm4_if.sv -----
// ---------------------------------------------------------------------------
// SM4 channel interfaces
// Valid/ready channels for blocks in, results out and key writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface sm4_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [63:0] block_hi;
   logic [63:0] block_lo;

   modport source (output valid, command, block_hi, block_lo, input ready);
   modport sink   (input valid, command, block_hi, block_lo, output ready);
endinterface

interface sm4_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_hi;
   logic [63:0] result_lo;

   modport source (output valid, result_hi, result_lo, input ready);
   modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface sm4_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sm4_round_unit.sv -----
// ---------------------------------------------------------------------------
// SM4 round unit
// One round, shared by key expansion (L') and data rounds (L).
// ---------------------------------------------------------------------------
`default_nettype none

module sm4_round_unit (
   input  sm4_pkg::word_type x0,
   input  sm4_pkg::word_type x1,
   input  sm4_pkg::word_type x2,
   input  sm4_pkg::word_type x3,
   input  sm4_pkg::word_type rk,
   input  logic              key_mode,
   output sm4_pkg::word_type nx
);
   import sm4_pkg::*;

   word_type t;

   always_comb begin
      t  = sub_word(x1 ^ x2 ^ x3 ^ rk);
      nx = x0 ^ (key_mode ? lin_key(t) : lin_data(t));
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sm4_key_store.sv -----
// ---------------------------------------------------------------------------
// SM4 round key store
// 32 x 32 memory, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module sm4_key_store (
   input  logic                  clock,
   input  logic                  wr_en,
   input  sm4_pkg::rk_addr_type  wr_addr,
   input  sm4_pkg::word_type     wr_data,
   input  sm4_pkg::rk_addr_type  rd_addr,
   output sm4_pkg::word_type     rd_data
);
   import sm4_pkg::*;

   word_type mem [ROUNDS];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sm4_block_cipher.sv -----
// ---------------------------------------------------------------------------
// SM4 block cipher
// 128-bit SM4 encrypt/decrypt engine, one round per clock, stored round keys.
// ---------------------------------------------------------------------------
// Usage: write the key through csr_port (index 0 = key bits 127..64, index 1
// = key bits 63..0, both big-endian), then send blocks on req_port with
// command 0 for encrypt or 1 for decrypt. Each block gives one result
// transaction on rsp_port. A block goes from accept to result through a load
// step, 32 rounds through the single shared round unit and an output step;
// the first block after a key write first waits for key expansion, in which
// the same round unit expands the key into the 32-entry round key store. One
// block is in flight at a time; req_port is ready again once the result has
// moved into the output register, so a new block can start while the
// previous result still waits. Key writes are taken only while idle, and a
// key write on offer holds off req_port for that cycle so the block that
// follows sees the new key.
`default_nettype none

`include "assert_macros.svh"

module sm4_block_cipher (
   input  logic      clock,
   input  logic      reset,
   sm4_req_if.sink   req_port,
   sm4_rsp_if.source rsp_port,
   sm4_csr_if.sink   csr_port
);
   import sm4_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXPAND = 5'b00010,   // key schedule, one round key per cycle
      ST_LOAD   = 5'b00100,   // load block, prefetch first round key
      ST_ROUND  = 5'b01000,   // data rounds
      ST_FINISH = 5'b10000    // hand result to output register
   } seq_state_type;

   localparam rk_addr_type LAST_ROUND = RK_AW'(ROUNDS - 1);

   // control state
   seq_state_type state_ff, state_in;
   rk_addr_type   cnt_ff, cnt_in;
   logic          keys_ready_ff, keys_ready_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   word_type  x_ff [4];
   word_type  x_in [4];
   dword_type blk_hi_ff, blk_lo_ff;
   logic      cmd_ff;
   dword_type key_hi_ff, key_lo_ff;
   dword_type rsp_hi_ff, rsp_lo_ff;

   // datapath wires
   logic        req_fire, csr_fire, out_free, key_mode, wr_en;
   word_type    rk, nx, rk_rd;
   rk_addr_type rd_idx, rd_addr;

   // key write goes first when both channels are offered in the same cycle
   assign req_port.ready     = (state_ff == ST_IDLE) && !csr_port.valid;
   assign csr_port.ready     = (state_ff == ST_IDLE);
   assign req_fire           = req_port.valid && req_port.ready;
   assign csr_fire           = csr_port.valid && csr_port.ready;
   assign out_free           = !rsp_valid_ff || rsp_port.ready;
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.result_hi = rsp_hi_ff;
   assign rsp_port.result_lo = rsp_lo_ff;

   // Shared round unit: key schedule uses CK and L', data rounds use the store.
   assign key_mode = (state_ff == ST_EXPAND);
   assign rk       = key_mode ? ck_word(cnt_ff) : rk_rd;
   assign wr_en    = key_mode;

   // Store read is registered, so address the key of the next round.
   assign rd_idx  = (state_ff == ST_ROUND) ? cnt_ff + 1'b1 : '0;
   assign rd_addr = cmd_ff ? LAST_ROUND - rd_idx : rd_idx;

   sm4_round_unit u_round (
      .x0       (x_ff[0]),
      .x1       (x_ff[1]),
      .x2       (x_ff[2]),
      .x3       (x_ff[3]),
      .rk       (rk),
      .key_mode (key_mode),
      .nx       (nx)
   );

   sm4_key_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff),
      .wr_data (nx),
      .rd_addr (rd_addr),
      .rd_data (rk_rd)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      keys_ready_in = keys_ready_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      x_in          = x_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_fire && (csr_port.index == REG_KEY_HI ||
                             csr_port.index == REG_KEY_LO)) begin
               keys_ready_in = 1'b0;
            end
            if (req_fire) begin
               // key words with FK applied, used only if expansion is due
               x_in[0]  = key_hi_ff[63:32] ^ FK[0];
               x_in[1]  = key_hi_ff[31:0]  ^ FK[1];
               x_in[2]  = key_lo_ff[63:32] ^ FK[2];
               x_in[3]  = key_lo_ff[31:0]  ^ FK[3];
               cnt_in   = '0;
               state_in = keys_ready_ff ? ST_LOAD : ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            x_in   = '{x_ff[1], x_ff[2], x_ff[3], nx};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ROUND) begin
               keys_ready_in = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         ST_LOAD: begin
            x_in     = '{blk_hi_ff[63:32], blk_hi_ff[31:0],
                         blk_lo_ff[63:32], blk_lo_ff[31:0]};
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            x_in   = '{x_ff[1], x_ff[2], x_ff[3], nx};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         keys_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         key_hi_ff     <= '0;
         key_lo_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         keys_ready_ff <= keys_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_fire && csr_port.index == REG_KEY_HI) begin
            key_hi_ff <= csr_port.data;
         end
         if (csr_fire && csr_port.index == REG_KEY_LO) begin
            key_lo_ff <= csr_port.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (req_fire) begin
         blk_hi_ff <= req_port.block_hi;
         blk_lo_ff <= req_port.block_lo;
         cmd_ff    <= req_port.command;
      end
      // output is X35,X34,X33,X32
      if (state_ff == ST_FINISH && out_free) begin
         rsp_hi_ff <= {x_ff[3], x_ff[2]};
         rsp_lo_ff <= {x_ff[1], x_ff[0]};
      end
   end

   `SM4_ASSERT(a_state_onehot, clock, reset, $onehot(state_ff))
   `SM4_ASSERT_IMPL(a_round_keys_ready, clock, reset, state_ff == ST_ROUND, keys_ready_ff)
   `SM4_ASSERT_IMPL(a_idle_cnt_zero, clock, reset, state_ff == ST_IDLE, cnt_ff == '0)
   `SM4_ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))

endmodule

`default_nettype wire
